FILE: hw/rtl/dcm_pkg.sv
// Shared types, constants and helpers for the DC motor model step core.
package dcm_pkg;

  // Default number of fraction bits in the fixed-point format.
  localparam int FRAC_BITS_DEF = 16;

  // Width of the exact products steps_per_second times a 31-bit register.
  localparam int DEN_W = 51;

  // Configuration register indexes.
  localparam logic [2:0] CFG_EM_FACTOR    = 3'd0;
  localparam logic [2:0] CFG_INDUCTANCE   = 3'd1;
  localparam logic [2:0] CFG_RESISTANCE   = 3'd2;
  localparam logic [2:0] CFG_MECH_TC      = 3'd3;
  localparam logic [2:0] CFG_GEAR_RATIO   = 3'd4;
  localparam logic [2:0] CFG_STEPS_PER_S  = 3'd5;
  localparam logic [2:0] CFG_BASE_LOAD    = 3'd6;

  // Register values after reset.
  localparam logic [30:0] RST_EM_FACTOR   = 31'd131072;
  localparam logic [30:0] RST_INDUCTANCE  = 31'd6554;
  localparam logic [30:0] RST_RESISTANCE  = 31'd65536;
  localparam logic [30:0] RST_MECH_TC     = 31'd6554;
  localparam logic [30:0] RST_GEAR_RATIO  = 31'd65536;
  localparam logic [19:0] RST_STEPS_PER_S = 20'd1000;
  localparam logic [31:0] RST_BASE_LOAD   = 32'd0;

  localparam logic [31:0] S32_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] S32_MIN = 32'h8000_0000;

  // Sequencer of the step core.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_M_DEL,
    ST_M_DMECH,
    ST_M_DANG,
    ST_M_VR,
    ST_D_T1,
    ST_D_RQ,
    ST_M_T2,
    ST_M_LR,
    ST_D_LR,
    ST_D_EMF,
    ST_M_MOM,
    ST_D_MOM,
    ST_D_SPD,
    ST_D_ANG,
    ST_OUT
  } step_state_t;

  // Sequencer of the serial divider.
  typedef enum logic [1:0] {
    DV_IDLE,
    DV_RUN,
    DV_FIN
  } div_state_t;

  // Clamp a 33-bit signed sum to the signed 32-bit range.
  function automatic logic [31:0] sat33(input logic [32:0] x);
    logic [31:0] res;
    begin
      if (x[32] != x[31]) begin
        res = x[32] ? S32_MIN : S32_MAX;
      end else begin
        res = x[31:0];
      end
      return res;
    end
  endfunction

endpackage

FILE: hw/rtl/dcm_div.sv
// Serial restoring divider: saturated signed quotient of (num * 2^FRAC_BITS) / den.
module dcm_div #(
  parameter int FRAC_BITS = dcm_pkg::FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     req,
  input  logic [31:0]              num,
  input  logic [dcm_pkg::DEN_W-1:0] den,
  output logic                     done,
  output logic [31:0]              quo
);
  import dcm_pkg::*;

  div_state_t          state_r;
  div_state_t          state_nxt;
  logic [DEN_W-1:0]    part_r;
  logic [DEN_W-1:0]    den_r;
  logic [31:0]         low_r;
  logic [4:0]          cnt_r;
  logic                neg_r;
  logic                sat_r;

  logic [31:0]             mag;
  logic [31+FRAC_BITS:0]   nwide;
  logic [DEN_W-1:0]        hi_ext;
  logic                    ovf;
  logic [DEN_W:0]          trial;
  logic [DEN_W-1:0]        diff;
  logic                    ge;
  logic [31:0]             neg_q;

  always_comb begin
    mag    = num[31] ? (~num + 32'd1) : num;
    nwide  = {mag, {FRAC_BITS{1'b0}}};
    hi_ext = {{(DEN_W-FRAC_BITS){1'b0}}, nwide[31+FRAC_BITS:32]};
    // A quotient of 2^32 or more saturates whatever its sign.
    ovf    = (hi_ext >= den);
    trial  = {part_r, low_r[31]};
    // The remainder is below the divisor, so the low bits of the difference are exact.
    diff   = trial[DEN_W-1:0] - den_r;
    ge     = (trial >= {1'b0, den_r});
    neg_q  = ~low_r + 32'd1;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      DV_IDLE: begin
        if (req) begin
          state_nxt = ovf ? DV_FIN : DV_RUN;
        end
      end
      DV_RUN: begin
        if (cnt_r == 5'd0) begin
          state_nxt = DV_FIN;
        end
      end
      DV_FIN:  state_nxt = DV_IDLE;
      default: state_nxt = DV_IDLE;
    endcase
  end

  always_comb begin
    done = (state_r == DV_FIN);
    if (sat_r) begin
      quo = neg_r ? S32_MIN : S32_MAX;
    end else if (neg_r) begin
      quo = (low_r > S32_MIN) ? S32_MIN : neg_q;
    end else begin
      quo = low_r[31] ? S32_MAX : low_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= DV_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      DV_IDLE: begin
        if (req) begin
          neg_r  <= num[31];
          sat_r  <= ovf;
          den_r  <= den;
          part_r <= hi_ext;
          low_r  <= nwide[31:0];
          cnt_r  <= 5'd31;
        end
      end
      DV_RUN: begin
        // The quotient bits shift into the low word as the dividend bits leave it.
        part_r <= ge ? diff : trial[DEN_W-1:0];
        low_r  <= {low_r[30:0], ge};
        cnt_r  <= cnt_r - 5'd1;
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: hw/rtl/dc_motor_model_step_core.sv
// Top level of the DC motor model step core: sequencer, shared multiplier and divider.
// One item runs through seven serial divisions and the multiplier steps before its result beat, and the next item is
// accepted only once the sequencer is back in idle, so the core does not take a new item while one is in flight.
// A division whose quotient is known to saturate skips the serial steps and goes straight to its finish state.
// Synchronous active-low reset clears the motor state, the sequencer and the output
// valid flag, and loads the configuration registers with their default values.
module dc_motor_model_step_core #(
  parameter int FRAC_BITS = dcm_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_voltage,
  input  logic [31:0] in_load_moment,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_shaft_moment,
  output logic [31:0] out_angular_speed,
  output logic [31:0] out_shaft_angle
);
  import dcm_pkg::*;

  localparam logic [65:0] RND_ADD = (66'd1 << FRAC_BITS) - 66'd1;
  localparam logic [32:0] Q_ONE   = 33'd1 << FRAC_BITS;

  // Configuration.
  logic [30:0] em_factor_r;
  logic [30:0] inductance_r;
  logic [30:0] resistance_r;
  logic [30:0] mech_tc_r;
  logic [30:0] gear_ratio_r;
  logic [19:0] steps_r;
  logic [31:0] base_load_r;

  // Motor state and working registers.
  logic [31:0]        cur_r;
  logic [31:0]        emf_r;
  logic [31:0]        ang_r;
  logic [31:0]        volt_r;
  logic [31:0]        load_r;
  logic [31:0]        t1_r;
  logic [31:0]        tmp_r;
  logic [31:0]        mom_r;
  logic [31:0]        spd_r;
  logic [DEN_W-1:0]   d_el_r;
  logic [DEN_W-1:0]   d_mech_r;
  logic [DEN_W-1:0]   d_ang_r;
  logic signed [65:0] prod_r;
  logic               out_valid_r;
  logic [31:0]        out_mom_r;
  logic [31:0]        out_spd_r;
  logic [31:0]        out_ang_r;

  step_state_t state_r;
  step_state_t state_nxt;

  // Effective divisors: a zero register acts as the smallest positive value.
  logic [30:0] k_eff;
  logic [30:0] ind_eff;
  logic [30:0] r_eff;
  logic [30:0] tm_eff;
  logic [30:0] gear_eff;
  logic [19:0] ts_eff;

  logic signed [32:0] mul_a;
  logic signed [32:0] mul_b;
  logic               div_req;
  logic [31:0]        div_num;
  logic [DEN_W-1:0]   div_den;
  logic               div_done;
  logic [31:0]        div_quo;

  logic               in_take;
  logic               out_load;
  logic signed [65:0] prod_adj;
  logic signed [65:0] prod_sh;
  logic [31:0]        qmul_q;
  logic [31:0]        vmine;

  dcm_div #(
    .FRAC_BITS(FRAC_BITS)
  ) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quo  (div_quo)
  );

  always_comb begin
    k_eff    = (em_factor_r  == 31'd0) ? 31'd1 : em_factor_r;
    ind_eff  = (inductance_r == 31'd0) ? 31'd1 : inductance_r;
    r_eff    = (resistance_r == 31'd0) ? 31'd1 : resistance_r;
    tm_eff   = (mech_tc_r    == 31'd0) ? 31'd1 : mech_tc_r;
    gear_eff = (gear_ratio_r == 31'd0) ? 31'd1 : gear_ratio_r;
    ts_eff   = (steps_r      == 20'd0) ? 20'd1 : steps_r;
  end

  // Fixed-point product from the registered full product: truncate toward zero, clamp.
  always_comb begin
    prod_adj = prod_r + (prod_r[65] ? $signed(RND_ADD) : 66'sd0);
    prod_sh  = prod_adj >>> FRAC_BITS;
    if (prod_sh > $signed({34'd0, S32_MAX})) begin
      qmul_q = S32_MAX;
    end else if (prod_sh < $signed({{34{1'b1}}, S32_MIN})) begin
      qmul_q = S32_MIN;
    end else begin
      qmul_q = prod_sh[31:0];
    end
    vmine = sat33({volt_r[31], volt_r} - {emf_r[31], emf_r});
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign in_take   = in_valid && (state_r == ST_IDLE);
  assign out_load  = (state_r == ST_OUT) && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_shaft_moment  = out_mom_r;
  assign out_angular_speed = out_spd_r;
  assign out_shaft_angle   = out_ang_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:    if (in_valid) state_nxt = ST_M_DEL;
      ST_M_DEL:   state_nxt = ST_M_DMECH;
      ST_M_DMECH: state_nxt = ST_M_DANG;
      ST_M_DANG:  state_nxt = ST_M_VR;
      ST_M_VR:    state_nxt = ST_D_T1;
      ST_D_T1:    if (div_done) state_nxt = ST_D_RQ;
      ST_D_RQ:    if (div_done) state_nxt = ST_M_T2;
      ST_M_T2:    state_nxt = ST_M_LR;
      ST_M_LR:    state_nxt = ST_D_LR;
      ST_D_LR:    if (div_done) state_nxt = ST_D_EMF;
      ST_D_EMF:   if (div_done) state_nxt = ST_M_MOM;
      ST_M_MOM:   state_nxt = ST_D_MOM;
      ST_D_MOM:   if (div_done) state_nxt = ST_D_SPD;
      ST_D_SPD:   if (div_done) state_nxt = ST_D_ANG;
      ST_D_ANG:   if (div_done) state_nxt = ST_OUT;
      ST_OUT:     if (!out_valid_r || !out_stall) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // Operand selection for the shared multiplier and divider.
  always_comb begin
    mul_a   = 33'sd0;
    mul_b   = 33'sd0;
    div_req = 1'b0;
    div_num = 32'd0;
    div_den = d_el_r;
    case (state_r)
      ST_M_DEL: begin
        mul_a = $signed({13'd0, ts_eff});
        mul_b = $signed({2'd0, ind_eff});
      end
      ST_M_DMECH: begin
        mul_a = $signed({13'd0, ts_eff});
        mul_b = $signed({2'd0, tm_eff});
      end
      ST_M_DANG: begin
        mul_a = $signed({2'd0, gear_eff});
        mul_b = $signed({13'd0, ts_eff});
      end
      ST_M_VR: begin
        mul_a = $signed({vmine[31], vmine});
        mul_b = $signed({2'd0, r_eff});
      end
      ST_D_T1: begin
        div_req = 1'b1;
        div_num = qmul_q;
        div_den = d_el_r;
      end
      ST_D_RQ: begin
        div_req = 1'b1;
        div_num = {1'b0, r_eff};
        div_den = d_el_r;
      end
      ST_M_T2: begin
        mul_a = $signed({tmp_r[31], tmp_r});
        mul_b = $signed({cur_r[31], cur_r});
      end
      ST_M_LR: begin
        mul_a = $signed({load_r[31], load_r});
        mul_b = $signed({2'd0, r_eff});
      end
      ST_D_LR: begin
        div_req = 1'b1;
        div_num = qmul_q;
        div_den = {20'd0, k_eff};
      end
      ST_D_EMF: begin
        div_req = 1'b1;
        div_num = tmp_r;
        div_den = d_mech_r;
      end
      ST_M_MOM: begin
        mul_a = $signed({cur_r[31], cur_r});
        mul_b = $signed({2'd0, k_eff});
      end
      ST_D_MOM: begin
        div_req = 1'b1;
        div_num = qmul_q;
        div_den = {20'd0, r_eff};
      end
      ST_D_SPD: begin
        div_req = 1'b1;
        div_num = emf_r;
        div_den = {20'd0, k_eff};
      end
      ST_D_ANG: begin
        div_req = 1'b1;
        div_num = spd_r;
        div_den = d_ang_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      cur_r       <= 32'd0;
      emf_r       <= 32'd0;
      ang_r       <= 32'd0;
      em_factor_r  <= RST_EM_FACTOR;
      inductance_r <= RST_INDUCTANCE;
      resistance_r <= RST_RESISTANCE;
      mech_tc_r    <= RST_MECH_TC;
      gear_ratio_r <= RST_GEAR_RATIO;
      steps_r      <= RST_STEPS_PER_S;
      base_load_r  <= RST_BASE_LOAD;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_EM_FACTOR:   em_factor_r  <= cfg_wdata[30:0];
          CFG_INDUCTANCE:  inductance_r <= cfg_wdata[30:0];
          CFG_RESISTANCE:  resistance_r <= cfg_wdata[30:0];
          CFG_MECH_TC:     mech_tc_r    <= cfg_wdata[30:0];
          CFG_GEAR_RATIO:  gear_ratio_r <= cfg_wdata[30:0];
          CFG_STEPS_PER_S: steps_r      <= cfg_wdata[19:0];
          CFG_BASE_LOAD:   base_load_r  <= cfg_wdata;
          default: begin
          end
        endcase
      end
      if ((state_r == ST_M_LR)) begin
        cur_r <= sat33({t1_r[31], t1_r} + {qmul_q[31], qmul_q});
      end
      if ((state_r == ST_D_EMF) && div_done) begin
        emf_r <= sat33({emf_r[31], emf_r} + {div_quo[31], div_quo});
      end
      if ((state_r == ST_D_ANG) && div_done) begin
        ang_r <= sat33({ang_r[31], ang_r} + {div_quo[31], div_quo});
      end
    end
  end

  // Datapath registers without reset.
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    if (in_take) begin
      volt_r <= in_voltage;
      load_r <= sat33({in_load_moment[31], in_load_moment} + {base_load_r[31], base_load_r});
    end
    case (state_r)
      ST_M_DMECH: d_el_r   <= prod_r[DEN_W-1:0];
      ST_M_DANG:  d_mech_r <= prod_r[DEN_W-1:0];
      ST_M_VR:    d_ang_r  <= prod_r[DEN_W-1:0];
      ST_D_T1:    if (div_done) t1_r <= div_quo;
      ST_D_RQ:    if (div_done) tmp_r <= sat33(Q_ONE - {div_quo[31], div_quo});
      ST_D_LR:    if (div_done) tmp_r <= sat33({cur_r[31], cur_r} - {div_quo[31], div_quo});
      ST_D_MOM:   if (div_done) mom_r <= div_quo;
      ST_D_SPD:   if (div_done) spd_r <= div_quo;
      default: begin
      end
    endcase
    if (out_load) begin
      out_mom_r <= mom_r;
      out_spd_r <= spd_r;
      out_ang_r <= ang_r;
    end
  end

endmodule
